@@ sv/tes_pkg.sv @@
// ----------------------------------------------------------------------------
// tes_pkg: shared types and codes of the tick event scheduler
// Beat layouts of the request and response channels, function and response
// codes, and field width constants.
// ----------------------------------------------------------------------------
`default_nettype none

package tes_pkg;

  localparam int unsigned TickW = 48;
  localparam int unsigned IdleW = 32;
  localparam int unsigned IdW   = 8;
  localparam int unsigned CntW  = 5;

  localparam logic [TickW-1:0] TickMax = '1;

  // request function codes
  typedef enum logic [2:0] {
    F_SUBSCRIBE = 3'd0,
    F_REMOVE    = 3'd1,
    F_REM_LK    = 3'd2,
    F_REM_L     = 3'd3,
    F_QUERY     = 3'd4,
    F_ADVANCE   = 3'd5
  } func_e;

  // response codes
  typedef enum logic [2:0] {
    R_STORED  = 3'd0,
    R_DUP     = 3'd1,
    R_FULL    = 3'd2,
    R_PRESENT = 3'd3,
    R_ABSENT  = 3'd4,
    R_FIRED   = 3'd5,
    R_NONE    = 3'd6
  } resp_e;

  typedef struct packed {
    logic [2:0]       func;
    logic [IdW-1:0]   listener_id;
    logic [IdW-1:0]   event_kind;
    logic [IdleW-1:0] idle_ticks;
    logic [TickW-1:0] target_tick;
  } tes_in_t;

  typedef struct packed {
    logic [2:0]       resp_code;
    logic [TickW-1:0] out_tick;
    logic [IdW-1:0]   out_kind;
    logic [IdW-1:0]   out_listener;
    logic [CntW-1:0]  removed_count;
    logic             last;
  } tes_out_t;

endpackage

`default_nettype wire

@@ sv/tes_if.sv @@
// ----------------------------------------------------------------------------
// tes_if: valid/ready channels of the tick event scheduler
// Request channel (tes_in_if) and response channel (tes_out_if).
// ----------------------------------------------------------------------------
`default_nettype none

interface tes_in_if import tes_pkg::*; ();
  logic    valid;
  logic    ready;
  tes_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tes_out_if import tes_pkg::*; ();
  logic     valid;
  logic     ready;
  tes_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ sv/tick_event_scheduler.sv @@
// ----------------------------------------------------------------------------
// tick_event_scheduler: sorted timer event queue on a tick counter
// Keeps a saturating tick count and a sorted, duplicate-free table of events
// in a RAM. One comparator and one RAM read port are swept over the table by
// a small sequencer for search, insert, removal and firing.
// ----------------------------------------------------------------------------
//
//  channel  dir  beat       handshake
//  req_i    in   tes_in_t   valid/ready, ready only while idle
//  rsp_o    out  tes_out_t  valid/ready, output register
//
//  One item at a time. The sweep reads one table entry per cycle through the
//  RAM read port while it is not stalled. Fired events wait in the sweep
//  while the response beat stalls. Reset clears the count and tick; the
//  table needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module tick_event_scheduler import tes_pkg::*; #(
  parameter int unsigned DEPTH         = 16,
  parameter int unsigned LISTENER_BITS = 8,
  parameter int unsigned KIND_BITS     = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tes_in_if.sink    req_i,
  tes_out_if.source rsp_o
);

  localparam int unsigned LB = LISTENER_BITS;
  localparam int unsigned KB = KIND_BITS;
  localparam int unsigned EW = TickW + KB + LB;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_FILT = 5'b00100,
    S_INS  = 5'b01000,
    S_RESP = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [TickW-1:0] cur_q, cur_d;
  logic [CW-1:0]    rd_idx_q, rd_idx_d;
  logic [CW-1:0]    dx_q, dx_d;
  logic             dv_q, dv_d;
  logic [CW-1:0]    w_q, w_d;
  logic [CW-1:0]    rem_q, rem_d;
  logic [CW-1:0]    n_q, n_d;
  logic [EW-1:0]    carry_q, carry_d;
  logic [TickW-1:0] key_tick_q, key_tick_d;
  logic [KB-1:0]    key_kind_q, key_kind_d;
  logic [LB-1:0]    key_lis_q, key_lis_d;
  func_e            func_q, func_d;
  logic             incl_q, incl_d;
  tes_out_t         resp_q, resp_d;
  logic             ovalid_q, ovalid_d;
  tes_out_t         opay_q, opay_d;

  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [EW-1:0]    wdata, rdata;
  logic             cmp_lt, cmp_eq;

  logic [TickW-1:0] rd_tick;
  logic [KB-1:0]    rd_kind;
  logic [LB-1:0]    rd_lis;
  logic [KB-1:0]    kind_in;
  logic [LB-1:0]    lis_in;
  logic [TickW:0]   sub_sum;
  logic [TickW-1:0] sub_tick;
  logic [TickW-1:0] cur_next;

  logic out_free, sweep, f5_drop, stall, consume, stop, more, issue, sweep_done;
  logic drop, hit_now;
  logic [CW-1:0] pos_now;

  // table storage
  tes_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // shared key comparator
  tes_cmp #(
    .KB (KB),
    .LB (LB)
  ) u_cmp (
    .entry_i (rdata),
    .key_i   ({key_tick_q, key_kind_q, key_lis_q}),
    .lt_o    (cmp_lt),
    .eq_o    (cmp_eq)
  );

  assign rd_tick = rdata[EW-1 -: TickW];
  assign rd_kind = rdata[LB +: KB];
  assign rd_lis  = rdata[LB-1:0];

  assign kind_in = KB'(req_i.payload.event_kind);
  assign lis_in  = LB'(req_i.payload.listener_id);

  // saturating subscription tick and tick increment
  assign sub_sum  = {1'b0, cur_q} + (TickW + 1)'(req_i.payload.idle_ticks);
  assign sub_tick = sub_sum[TickW] ? TickMax : sub_sum[TickW-1:0];
  assign cur_next = (cur_q == TickMax) ? cur_q : cur_q + TickW'(1);

  assign req_i.ready   = (state_q == S_IDLE);
  assign rsp_o.valid   = ovalid_q;
  assign rsp_o.payload = opay_q;

  // sweep pipeline: issue read, then consume the registered entry
  assign out_free   = !ovalid_q || rsp_o.ready;
  assign sweep      = (state_q == S_SCAN) || (state_q == S_FILT) || (state_q == S_INS);
  assign f5_drop    = (func_q == F_ADVANCE) && (dx_q < n_q);
  assign stall      = (state_q == S_FILT) && dv_q && f5_drop && !out_free;
  assign consume    = sweep && dv_q && !stall;
  assign stop       = (state_q == S_SCAN) && consume && !(cmp_lt || (incl_q && cmp_eq));
  assign more       = rd_idx_q < cnt_q;
  assign issue      = sweep && more && (!dv_q || consume) && !stop;
  assign sweep_done = !more && !dv_q;
  assign pos_now    = stop ? dx_q : cnt_q;
  assign hit_now    = stop && cmp_eq;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cur_d      = cur_q;
    rd_idx_d   = rd_idx_q;
    dx_d       = dx_q;
    w_d        = w_q;
    rem_d      = rem_q;
    n_d        = n_q;
    carry_d    = carry_q;
    key_tick_d = key_tick_q;
    key_kind_d = key_kind_q;
    key_lis_d  = key_lis_q;
    func_d     = func_q;
    incl_d     = incl_q;
    resp_d     = resp_q;
    ovalid_d   = ovalid_q;
    opay_d     = opay_q;
    we         = 1'b0;
    waddr      = w_q[AW-1:0];
    wdata      = rdata;
    re         = issue;
    raddr      = rd_idx_q[AW-1:0];
    drop       = 1'b0;

    if (ovalid_q && rsp_o.ready) begin
      ovalid_d = 1'b0;
    end

    // read pipeline bookkeeping
    dv_d = issue || (dv_q && !consume);
    if (issue) begin
      rd_idx_d = rd_idx_q + CW'(1);
      dx_d     = rd_idx_q;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          key_tick_d = req_i.payload.target_tick;
          key_kind_d = kind_in;
          key_lis_d  = lis_in;
          incl_d     = 1'b0;
          func_d     = func_e'(req_i.payload.func);
          rd_idx_d   = '0;
          w_d        = '0;
          rem_d      = '0;
          unique case (func_e'(req_i.payload.func))
            F_SUBSCRIBE: begin
              key_tick_d = sub_tick;
              state_d    = S_SCAN;
            end
            F_REMOVE, F_REM_LK, F_REM_L: state_d = S_FILT;
            F_QUERY: state_d = S_SCAN;
            F_ADVANCE: begin
              cur_d      = cur_next;
              key_tick_d = cur_next;
              key_kind_d = '1;
              key_lis_d  = '1;
              incl_d     = 1'b1;
              state_d    = S_SCAN;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_SCAN: begin
        if (stop || sweep_done) begin
          resp_d.resp_code     = hit_now ? R_PRESENT : R_ABSENT;
          resp_d.out_tick      = key_tick_q;
          resp_d.out_kind      = IdW'(key_kind_q);
          resp_d.out_listener  = IdW'(key_lis_q);
          resp_d.removed_count = '0;
          resp_d.last          = 1'b1;
          state_d              = S_RESP;
          unique case (func_q)
            F_SUBSCRIBE: begin
              if (hit_now) begin
                resp_d.resp_code = R_DUP;
              end else if (cnt_q == CW'(DEPTH)) begin
                resp_d.resp_code = R_FULL;
              end else begin
                carry_d  = {key_tick_q, key_kind_q, key_lis_q};
                rd_idx_d = pos_now;
                state_d  = S_INS;
              end
            end
            F_ADVANCE: begin
              if (pos_now == '0) begin
                resp_d.resp_code    = R_NONE;
                resp_d.out_tick     = cur_q;
                resp_d.out_kind     = '0;
                resp_d.out_listener = '0;
              end else begin
                n_d      = pos_now;
                rd_idx_d = '0;
                w_d      = '0;
                state_d  = S_FILT;
              end
            end
            default: ;
          endcase
        end
      end

      // shift entries up from the insert position, carrying one entry
      S_INS: begin
        if (consume) begin
          we      = 1'b1;
          waddr   = dx_q[AW-1:0];
          wdata   = carry_q;
          carry_d = rdata;
        end
        if (sweep_done) begin
          we               = 1'b1;
          waddr            = cnt_q[AW-1:0];
          wdata            = carry_q;
          cnt_d            = cnt_q + CW'(1);
          resp_d.resp_code = R_STORED;
          state_d          = S_RESP;
        end
      end

      // compact the table, dropping matching or due entries
      S_FILT: begin
        if (consume) begin
          unique case (func_q)
            F_REMOVE:  drop = cmp_eq;
            F_REM_LK:  drop = (rd_lis == key_lis_q) && (rd_kind == key_kind_q);
            F_REM_L:   drop = (rd_lis == key_lis_q);
            F_ADVANCE: drop = f5_drop;
            default:   drop = 1'b0;
          endcase
          if (drop) begin
            rem_d = rem_q + CW'(1);
            if (func_q == F_ADVANCE) begin
              ovalid_d              = 1'b1;
              opay_d.resp_code      = R_FIRED;
              opay_d.out_tick       = rd_tick;
              opay_d.out_kind       = IdW'(rd_kind);
              opay_d.out_listener   = IdW'(rd_lis);
              opay_d.removed_count  = '0;
              opay_d.last           = (dx_q + CW'(1)) == n_q;
            end
          end else begin
            we    = 1'b1;
            waddr = w_q[AW-1:0];
            wdata = rdata;
            w_d   = w_q + CW'(1);
          end
        end
        if (sweep_done) begin
          cnt_d                = w_q;
          resp_d.resp_code     = (rem_q != '0) ? R_PRESENT : R_ABSENT;
          resp_d.out_tick      = key_tick_q;
          resp_d.out_kind      = IdW'(key_kind_q);
          resp_d.out_listener  = IdW'(key_lis_q);
          resp_d.removed_count = CntW'(rem_q);
          resp_d.last          = 1'b1;
          state_d              = S_RESP;
          unique case (func_q)
            F_ADVANCE: state_d = S_IDLE;
            F_REM_LK:  resp_d.out_tick = '0;
            F_REM_L: begin
              resp_d.out_tick = '0;
              resp_d.out_kind = '0;
            end
            default: ;
          endcase
        end
      end

      S_RESP: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          opay_d   = resp_q;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      cur_q    <= '0;
      rd_idx_q <= '0;
      dv_q     <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      cur_q    <= cur_d;
      rd_idx_q <= rd_idx_d;
      dv_q     <= dv_d;
      ovalid_q <= ovalid_d;
    end
  end

  // payload and work registers
  always_ff @(posedge clk_i) begin
    dx_q       <= dx_d;
    w_q        <= w_d;
    rem_q      <= rem_d;
    n_q        <= n_d;
    carry_q    <= carry_d;
    key_tick_q <= key_tick_d;
    key_kind_q <= key_kind_d;
    key_lis_q  <= key_lis_d;
    func_q     <= func_d;
    incl_q     <= incl_d;
    resp_q     <= resp_d;
    opay_q     <= opay_d;
  end

`ifndef SYNTH
  // table never overfills
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count above table depth");

  // RAM is written only by a sweep
  a_we_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> sweep)
    else $error("table write outside a sweep");

  // read pipeline is drained whenever a new item can enter
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !dv_q)
    else $error("read pipeline busy while idle");

  // a result is never loaded over one that is still stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !rsp_o.ready) |=> ($stable(opay_q) && ovalid_q))
    else $error("stalled result overwritten");
`endif

endmodule

`default_nettype wire

@@ sv/tes_ram.sv @@
// ----------------------------------------------------------------------------
// tes_ram: generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module tes_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ sv/tes_cmp.sv @@
// ----------------------------------------------------------------------------
// tes_cmp: shared key comparator
// Orders a table entry against the search key by (tick, kind, listener).
// ----------------------------------------------------------------------------
`default_nettype none

module tes_cmp import tes_pkg::*; #(
  parameter int unsigned KB = 8,
  parameter int unsigned LB = 8
) (
  input  wire logic [TickW+KB+LB-1:0] entry_i,
  input  wire logic [TickW+KB+LB-1:0] key_i,
  output logic                        lt_o,
  output logic                        eq_o
);

  // packed key order equals the lexicographic order of the fields
  assign lt_o = entry_i < key_i;
  assign eq_o = entry_i == key_i;

endmodule

`default_nettype wire
